### hw/rtl/shs_pkg.sv
// Shared types, constants and bit functions for the SHA-256 stream hasher.
`default_nettype none

package shs_pkg;

  // Sequencer states of the hasher.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_ADD,
    ST_PAD,
    ST_OUT
  } state_t;

  // Eight 32-bit words: working variables a..h or hash words H0..H7, index 0 first.
  typedef logic [7:0][31:0] vars_t;

  // Control from the sequencer to the message schedule.
  typedef struct packed {
    logic       load;
    logic       step;
    logic [7:0] data;
  } sched_ctrl_t;

  localparam logic [7:0] PAD_MARKER = 8'h80;

  localparam logic [31:0] HASH_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr32(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

`default_nettype wire

### hw/rtl/shs_sched.sv
// Message block shift register: byte loading and rolling 16-word schedule expansion.
`default_nettype none

module shs_sched
  import shs_pkg::*;
(
  input  wire logic        clk,
  input  wire sched_ctrl_t sched_ctrl_i,
  output logic [31:0]      w_o
);

  // Word 0 (oldest) sits in the top 32 bits.
  logic [511:0] sched_r;
  logic [511:0] sched_nxt;
  logic [31:0]  w0, w1, w9, w14;
  logic [31:0]  s0, s1, w_new;

  assign w0  = sched_r[511:480];
  assign w1  = sched_r[479:448];
  assign w9  = sched_r[223:192];
  assign w14 = sched_r[63:32];

  assign s0    = rotr32(w1, 7) ^ rotr32(w1, 18) ^ (w1 >> 3);
  assign s1    = rotr32(w14, 17) ^ rotr32(w14, 19) ^ (w14 >> 10);
  assign w_new = s1 + w9 + s0 + w0;

  assign w_o = w0;

  always_comb begin
    sched_nxt = sched_r;
    if (sched_ctrl_i.load) begin
      sched_nxt = {sched_r[503:0], sched_ctrl_i.data};
    end else if (sched_ctrl_i.step) begin
      sched_nxt = {sched_r[479:0], w_new};
    end
  end

  always_ff @(posedge clk) begin
    sched_r <= sched_nxt;
  end

endmodule

`default_nettype wire

### hw/rtl/shs_round.sv
// One SHA-256 compression round on the working variables.
`default_nettype none

module shs_round
  import shs_pkg::*;
(
  input  wire vars_t       vars_i,
  input  wire logic [31:0] w_i,
  input  wire logic [31:0] k_i,
  output vars_t            vars_o
);

  logic [31:0] a, b, c, d, e, f, g, h;
  logic [31:0] big_s0, big_s1, ch, maj, t1, t2;

  assign a = vars_i[0];
  assign b = vars_i[1];
  assign c = vars_i[2];
  assign d = vars_i[3];
  assign e = vars_i[4];
  assign f = vars_i[5];
  assign g = vars_i[6];
  assign h = vars_i[7];

  assign big_s1 = rotr32(e, 6) ^ rotr32(e, 11) ^ rotr32(e, 25);
  assign big_s0 = rotr32(a, 2) ^ rotr32(a, 13) ^ rotr32(a, 22);
  assign ch     = (e & f) ^ (~e & g);
  assign maj    = (a & b) ^ (a & c) ^ (b & c);
  assign t1     = h + big_s1 + ch + k_i + w_i;
  assign t2     = big_s0 + maj;

  always_comb begin
    vars_o[0] = t1 + t2;
    vars_o[1] = a;
    vars_o[2] = b;
    vars_o[3] = c;
    vars_o[4] = d + t1;
    vars_o[5] = e;
    vars_o[6] = f;
    vars_o[7] = g;
  end

endmodule

`default_nettype wire

### hw/rtl/sha256_stream_hasher.sv
// Top level of the SHA-256 stream hasher: sequencer, hash state and digest output.
//
//   Channel | Direction | Ports                                          | Moves
//   in      | input     | in_valid/in_ready, has_byte, data_byte, last   | one message byte request
//   out     | output    | out_valid/out_ready, digest_word, index, last  | one digest word request
//
// The 64th byte of a block starts the rounds on the single round unit, then an add into the
// hash. A final request pads one byte per cycle up to the block end, runs one or two further
// compressions, then offers eight words, one per cycle while out_ready is high.
// Reset is synchronous; no memory clearing pass is needed.
// in_ready is low while compressing, padding or emitting; out_ready low holds the word.
`default_nettype none

module sha256_stream_hasher
  import shs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_has_byte,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_digest_word,
  output logic [2:0]       out_word_index,
  output logic             out_last_word
);

  state_t      state_r, state_nxt;
  logic [5:0]  round_r, round_nxt;
  logic [5:0]  fill_r, fill_nxt;
  logic [63:0] length_r, length_nxt;
  vars_t       hash_r, hash_nxt;
  vars_t       vars_r, vars_nxt;
  vars_t       round_out;
  logic        last_pend_r, last_pend_nxt;
  logic        final_r, final_nxt;
  logic        marker_done_r, marker_done_nxt;
  logic        marker_tail_r, marker_tail_nxt;
  logic [2:0]  idx_r, idx_nxt;

  logic        in_fire, out_fire;
  logic        fill_last;
  logic        in_tail;
  logic [7:0]  pad_byte;
  logic [7:0]  len_byte;
  logic [31:0] sched_w;
  sched_ctrl_t sched_ctrl;

  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;
  assign fill_last = (fill_r == 6'd63);
  assign in_tail   = (fill_r[5:3] == 3'b111);

  // Length bytes go out most significant first at buffer positions 56 to 63.
  assign len_byte = 8'(length_r >> {~fill_r[2:0], 3'b000});

  always_comb begin
    if (!marker_done_r) begin
      pad_byte = PAD_MARKER;
    end else if (in_tail && !marker_tail_r) begin
      pad_byte = len_byte;
    end else begin
      pad_byte = 8'h00;
    end
  end

  shs_sched u_sched (
    .clk          (clk),
    .sched_ctrl_i (sched_ctrl),
    .w_o          (sched_w)
  );

  shs_round u_round (
    .vars_i (vars_r),
    .w_i    (sched_w),
    .k_i    (ROUND_K[round_r]),
    .vars_o (round_out)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_has_byte && fill_last) begin
            state_nxt = ST_ROUND;
          end else if (in_last_byte) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_ROUND: begin
        if (round_r == 6'd63) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        if (final_r) begin
          state_nxt = ST_OUT;
        end else if (last_pend_r) begin
          state_nxt = ST_PAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_PAD: begin
        if (fill_last) begin
          state_nxt = ST_ROUND;
        end
      end
      ST_OUT: begin
        if (out_ready && (idx_r == 3'd7)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    in_ready        = 1'b0;
    out_valid       = 1'b0;
    sched_ctrl.load = 1'b0;
    sched_ctrl.step = 1'b0;
    sched_ctrl.data = in_data_byte;
    case (state_r)
      ST_IDLE: begin
        in_ready        = 1'b1;
        sched_ctrl.load = in_valid && in_has_byte;
      end
      ST_ROUND: begin
        sched_ctrl.step = 1'b1;
      end
      ST_PAD: begin
        sched_ctrl.load = 1'b1;
        sched_ctrl.data = pad_byte;
      end
      ST_OUT: begin
        out_valid = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign out_digest_word = hash_r[idx_r];
  assign out_word_index  = idx_r;
  assign out_last_word   = (idx_r == 3'd7);

  // Datapath and flag updates.
  always_comb begin
    round_nxt       = round_r;
    fill_nxt        = fill_r;
    length_nxt      = length_r;
    hash_nxt        = hash_r;
    vars_nxt        = vars_r;
    last_pend_nxt   = last_pend_r;
    final_nxt       = final_r;
    marker_done_nxt = marker_done_r;
    marker_tail_nxt = marker_tail_r;
    idx_nxt         = idx_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          last_pend_nxt = in_last_byte;
          if (in_has_byte) begin
            fill_nxt   = fill_r + 6'd1;
            length_nxt = length_r + 64'd8;
            if (fill_last) begin
              vars_nxt  = hash_r;
              final_nxt = 1'b0;
            end
          end
        end
      end
      ST_ROUND: begin
        vars_nxt  = round_out;
        round_nxt = round_r + 6'd1;
      end
      ST_ADD: begin
        for (int j = 0; j < 8; j++) begin
          hash_nxt[j] = hash_r[j] + vars_r[j];
        end
      end
      ST_PAD: begin
        fill_nxt        = fill_r + 6'd1;
        marker_done_nxt = 1'b1;
        if (!marker_done_r) begin
          marker_tail_nxt = in_tail;
        end
        if (fill_last) begin
          // The length lands in this block only if the marker was placed early enough.
          vars_nxt        = hash_r;
          final_nxt       = marker_done_r && !marker_tail_r;
          marker_tail_nxt = 1'b0;
        end
      end
      ST_OUT: begin
        if (out_ready) begin
          idx_nxt = idx_r + 3'd1;
          if (idx_r == 3'd7) begin
            for (int j = 0; j < 8; j++) begin
              hash_nxt[j] = HASH_IV[j];
            end
            length_nxt      = 64'd0;
            fill_nxt        = 6'd0;
            last_pend_nxt   = 1'b0;
            final_nxt       = 1'b0;
            marker_done_nxt = 1'b0;
            marker_tail_nxt = 1'b0;
          end
        end
      end
      default: begin
        round_nxt = round_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      round_r       <= 6'd0;
      fill_r        <= 6'd0;
      length_r      <= 64'd0;
      last_pend_r   <= 1'b0;
      final_r       <= 1'b0;
      marker_done_r <= 1'b0;
      marker_tail_r <= 1'b0;
      idx_r         <= 3'd0;
      for (int j = 0; j < 8; j++) begin
        hash_r[j] <= HASH_IV[j];
      end
    end else begin
      state_r       <= state_nxt;
      round_r       <= round_nxt;
      fill_r        <= fill_nxt;
      length_r      <= length_nxt;
      last_pend_r   <= last_pend_nxt;
      final_r       <= final_nxt;
      marker_done_r <= marker_done_nxt;
      marker_tail_r <= marker_tail_nxt;
      idx_r         <= idx_nxt;
      hash_r        <= hash_nxt;
    end
  end

  always_ff @(posedge clk) begin
    vars_r <= vars_nxt;
  end

`ifndef NO_ASSERTIONS
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input and output channels active together");

  a_last_word_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && out_last_word |=> in_ready && !out_valid)
    else $error("hasher not idle after final digest word");

  a_rounds_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND) && (round_r == 6'd63) |=> (state_r == ST_ADD) && (round_r == 6'd0))
    else $error("round sequence did not end in the hash update");

  a_final_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_last_byte |=> !in_ready)
    else $error("input accepted while a digest is pending");

  a_digest_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> (out_word_index == 3'd0) && $past(state_r == ST_ADD))
    else $error("digest output did not start at word zero after compression");
`endif

endmodule

`default_nettype wire

### tb/sha256_digest_checker.sv
// Checker for the SHA-256 stream hasher: predicts each digest from the accepted requests.
`timescale 1ns / 1ps

module sha256_digest_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_has_byte,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] out_digest_word,
  input  logic [2:0]  out_word_index,
  input  logic        out_last_word,
  output int          fail_count,
  output int          words_due
);

  localparam logic [7:0] END_MARKER = 8'h80;

  localparam logic [31:0] START_CHAIN [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_ADD [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

  digest_word_t digest_q[$];

  logic [31:0] chain[8];
  logic [7:0]  block_bytes[64];
  int unsigned block_fill;
  logic [63:0] message_bits;
  int          mismatches = 0;

  assign fail_count = mismatches;

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void restart_message();
    for (int i = 0; i < 8; i++) chain[i] = START_CHAIN[i];
    block_fill = 0;
    message_bits = '0;
  endfunction

  function automatic void compress_block();
    logic [31:0] w[16];
    logic [31:0] v[8];
    logic [31:0] s0, s1, t1, t2;
    for (int i = 0; i < 16; i++) begin
      w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2], block_bytes[4*i+3]};
    end
    for (int i = 0; i < 8; i++) v[i] = chain[i];
    for (int r = 0; r < 64; r++) begin
      // The schedule is kept as a rolling window of sixteen words.
      if (r >= 16) begin
        s0 = ror(w[(r + 1) % 16], 7) ^ ror(w[(r + 1) % 16], 18) ^ (w[(r + 1) % 16] >> 3);
        s1 = ror(w[(r + 14) % 16], 17) ^ ror(w[(r + 14) % 16], 19) ^ (w[(r + 14) % 16] >> 10);
        w[r % 16] = w[r % 16] + s0 + w[(r + 9) % 16] + s1;
      end
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_ADD[r] + w[r % 16];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain[i] = chain[i] + v[i];
  endfunction

  function automatic void absorb_request(input logic has, input logic [7:0] data,
                                         input logic last);
    if (has) begin
      block_bytes[block_fill] = data;
      block_fill++;
      message_bits = message_bits + 64'd8;
      if (block_fill == 64) begin
        compress_block();
        block_fill = 0;
      end
    end
    if (!last) return;
    block_bytes[block_fill] = END_MARKER;
    block_fill++;
    // No room for the length field: close this block and pad a further one.
    if (block_fill > 56) begin
      while (block_fill < 64) begin
        block_bytes[block_fill] = 8'h00;
        block_fill++;
      end
      compress_block();
      block_fill = 0;
    end
    while (block_fill < 56) begin
      block_bytes[block_fill] = 8'h00;
      block_fill++;
    end
    for (int k = 0; k < 8; k++) block_bytes[56 + k] = message_bits[63 - 8*k -: 8];
    compress_block();
    for (int k = 0; k < 8; k++) digest_q.push_back({chain[k], 3'(k), k == 7});
    restart_message();
  endfunction

  always @(posedge clk) begin : watch
    digest_word_t want;
    if (!rst_n) begin
      restart_message();
      digest_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (digest_q.size() == 0) begin
          $error("digest_word: expected none, got %h", out_digest_word);
          mismatches++;
        end else begin
          want = digest_q.pop_front();
          if (out_digest_word !== want.word) begin
            $error("digest_word: expected %h, got %h", want.word, out_digest_word);
            mismatches++;
          end
          if (out_word_index !== want.index) begin
            $error("word_index: expected %0d, got %0d", want.index, out_word_index);
            mismatches++;
          end
          if (out_last_word !== want.last) begin
            $error("last_word: expected %b, got %b", want.last, out_last_word);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) absorb_request(in_has_byte, in_data_byte, in_last_byte);
    end
    words_due <= digest_q.size();
  end

endmodule

### tb/sha256_stream_hasher_test.sv
// Testbench top for the SHA-256 stream hasher: message stimulus, handshake idling and verdict.
`timescale 1ns / 1ps

module sha256_stream_hasher_test;

  localparam int CYCLE_LIMIT = 400000;
  localparam int BYTE_TARGET = 380;
  localparam int BOUNDARY_LEN [9] = '{55, 56, 57, 63, 64, 65, 119, 120, 128};

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_has_byte = 1'b0;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;

  int          fail_count;
  int          words_due;
  int          request_count = 0;
  int          cycle_count = 0;
  bit          source_calm = 1'b0;
  bit          sink_calm = 1'b0;

  sha256_stream_hasher i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_has_byte     (in_has_byte),
    .in_data_byte    (in_data_byte),
    .in_last_byte    (in_last_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_digest_word (out_digest_word),
    .out_word_index  (out_word_index),
    .out_last_word   (out_last_word)
  );

  sha256_digest_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_has_byte     (in_has_byte),
    .in_data_byte    (in_data_byte),
    .in_last_byte    (in_last_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_digest_word (out_digest_word),
    .out_word_index  (out_word_index),
    .out_last_word   (out_last_word),
    .fail_count      (fail_count),
    .words_due       (words_due)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("sha256_stream_hasher_test: done, errors");
      $finish;
    end
  end

  // Mostly random waits, with occasional stretches of none at all.
  function automatic int unsigned draw_wait(inout bit calm);
    if ($urandom_range(0, 31) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 15);
  endfunction

  // Ready is sampled at the falling edge, so it is the value the next rising edge sees.
  task automatic send_request(input bit has, input logic [7:0] data, input bit last);
    int unsigned gap;
    bit taken;
    gap = draw_wait(source_calm);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_has_byte  <= has;
    in_data_byte <= data;
    in_last_byte <= last;
    do begin
      @(negedge clk);
      taken = (in_ready === 1'b1);
      @(posedge clk);
    end while (!taken);
    request_count++;
  endtask

  // Random bytes, with the odd empty request mixed in; the end comes on the
  // final byte or on a separate request without one.
  task automatic send_message(input int n_bytes, input bit end_on_byte);
    for (int i = 0; i < n_bytes; i++) begin
      if ($urandom_range(0, 7) == 0) send_request(1'b0, 8'($urandom), 1'b0);
      send_request(1'b1, 8'($urandom), end_on_byte && (i == n_bytes - 1));
    end
    if (!end_on_byte || n_bytes == 0) send_request(1'b0, 8'($urandom), 1'b1);
  endtask

  initial begin : result_sink
    int unsigned gap;
    bit taken;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      gap = draw_wait(sink_calm);
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do begin
        @(negedge clk);
        taken = (out_valid === 1'b1);
        @(posedge clk);
      end while (!taken);
    end
  end

  initial begin : stimulus
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty message, with a data byte that must be ignored.
    send_request(1'b0, 8'hff, 1'b1);
    // A request with neither byte nor end changes nothing.
    send_request(1'b0, 8'h00, 1'b0);
    send_request(1'b1, 8'h00, 1'b1);
    send_request(1'b1, 8'hff, 1'b1);
    send_request(1'b1, 8'h61, 1'b0);
    send_request(1'b1, 8'h62, 1'b0);
    send_request(1'b1, 8'h63, 1'b1);
    send_request(1'b1, 8'h61, 1'b0);
    send_request(1'b1, 8'h62, 1'b0);
    send_request(1'b1, 8'h63, 1'b0);
    send_request(1'b0, 8'hff, 1'b1);
    send_request(1'b1, 8'h5a, 1'b0);
    send_request(1'b0, 8'ha5, 1'b0);
    send_request(1'b0, 8'h00, 1'b1);

    while (request_count < BYTE_TARGET) begin
      if ($urandom_range(0, 3) == 0) begin
        send_message(BOUNDARY_LEN[$urandom_range(0, 8)], 1'($urandom_range(0, 1)));
      end else begin
        send_message($urandom_range(0, 40), 1'($urandom_range(0, 1)));
      end
    end
    in_valid <= 1'b0;

    // The checker counts the final request's words at the edge that accepted it.
    @(negedge clk);
    while (words_due != 0) @(negedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0) begin
      $display("sha256_stream_hasher_test: done, clean");
    end else begin
      $display("sha256_stream_hasher_test: done, errors");
    end
    $finish;
  end

endmodule
